[sv/wwm_pkg.sv]
// Shared types, constants and helpers for the wildcard word matcher.
`default_nettype none

package wwm_pkg;

  // Longest word that counts as valid, and the pattern capacity.
  localparam int unsigned MaxLen   = 40;
  localparam int unsigned PosW     = 6;
  localparam int unsigned NumPatW  = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [7:0] WildChar = 8'h3F;  // '?'
  localparam logic [7:0] UpperA   = 8'd65;
  localparam logic [7:0] UpperZ   = 8'd90;
  localparam logic [7:0] LowerA   = 8'd97;
  localparam logic [7:0] LowerZ   = 8'd122;
  localparam logic [7:0] CaseStep = 8'd32;

  // Match modes; code 3 is unused and never matches.
  typedef enum logic [1:0] {
    MODE_EXACT  = 2'd0,
    MODE_PREFIX = 2'd1,
    MODE_ANY    = 2'd2
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE = 3'd0,
    REG_PLEN = 3'd1,
    REG_PAT0 = 3'd2,
    REG_PAT1 = 3'd3,
    REG_PAT2 = 3'd4,
    REG_PAT3 = 3'd5,
    REG_PAT4 = 3'd6
  } cfg_reg_e;

  // Configuration as seen by the match logic.
  typedef struct packed {
    logic [1:0]             mode;
    logic [PosW-1:0]        plen;
    logic [MaxLen-1:0][7:0] pat;
  } cfg_t;

  // One input beat.
  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       last;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic matched;
    logic word_ok;
  } res_t;

  // Fold A..Z to lower case, leave everything else alone.
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= UpperA && c <= UpperZ) begin
      r = c + CaseStep;
    end
    return r;
  endfunction

  function automatic logic alpha_char(input logic [7:0] c);
    return (c >= UpperA && c <= UpperZ) || (c >= LowerA && c <= LowerZ);
  endfunction

endpackage

`default_nettype wire

[sv/wwm_cfg_regs.sv]
// Configuration register file: mode, pattern length and pattern bytes.
`default_nettype none

module wwm_cfg_regs
  import wwm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                     cfg_o
);

  logic [1:0]                          mode_q;
  logic [PosW-1:0]                     plen_q;
  logic [NumPatW-1:0][CfgDataW-1:0]    pat_q;

  // Writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
      plen_q <= '0;
      pat_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MODE: mode_q   <= cfg_data_i[1:0];
        REG_PLEN: plen_q   <= cfg_data_i[PosW-1:0];
        REG_PAT0: pat_q[0] <= cfg_data_i;
        REG_PAT1: pat_q[1] <= cfg_data_i;
        REG_PAT2: pat_q[2] <= cfg_data_i;
        REG_PAT3: pat_q[3] <= cfg_data_i;
        REG_PAT4: pat_q[4] <= cfg_data_i;
        default: ;  // index outside the map: ignored
      endcase
    end
  end

  assign cfg_o.mode = mode_q;
  assign cfg_o.plen = plen_q;
  assign cfg_o.pat  = pat_q;

endmodule

`default_nettype wire

[sv/wwm_in_reg.sv]
// Input register stage: holds one beat until the match stage takes it.
`default_nettype none

module wwm_in_reg
  import wwm_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  input  wire item_t item_i,
  input  wire logic  take_i,
  output logic       valid_o,
  output item_t      item_o
);

  logic  valid_q;
  logic  valid_d;
  item_t item_q;
  logic  load;

  // Stall only when a held beat is not being consumed this cycle
  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

[sv/wwm_match.sv]
// Per-word match state and its combinational update for one character.
`default_nettype none

module wwm_match
  import wwm_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  step_i,
  input  wire item_t item_i,
  output res_t       res_o
);

  logic [PosW-1:0]   pos_q,   pos_d,   pos_n;
  logic              pref_q,  pref_d,  pref_n;
  logic [MaxLen-1:0] win_q,   win_d,   win_n;
  logic              found_q, found_d, found_n;
  logic              bad_q,   bad_d,   bad_n;

  logic [7:0]        c;
  logic [MaxLen-1:0] mask;
  logic              plen_le_max;
  logic              plen_ok;
  logic [PosW-1:0]   plen_m1;
  logic              hit;

  assign c           = fold_case(item_i.ch);
  assign plen_le_max = cfg_i.plen <= PosW'(MaxLen);
  assign plen_ok     = plen_le_max && (cfg_i.plen != '0);
  assign plen_m1     = cfg_i.plen - PosW'(1);

  // Pattern positions that accept this character
  always_comb begin
    for (int j = 0; j < MaxLen; j++) begin
      mask[j] = (PosW'(j) < cfg_i.plen) &&
                (cfg_i.pat[j] == WildChar || cfg_i.pat[j] == c);
    end
  end

  // Fold one character into the word state
  always_comb begin
    pos_n   = pos_q;
    pref_n  = pref_q;
    win_n   = win_q;
    found_n = found_q;
    bad_n   = bad_q;
    if (item_i.has_char) begin
      if (!alpha_char(c)) begin
        bad_n = 1'b1;
      end
      if (pos_q >= PosW'(MaxLen)) begin
        bad_n = 1'b1;
      end else begin
        if (plen_le_max && pos_q < cfg_i.plen) begin
          if (!(cfg_i.pat[pos_q] == WildChar || cfg_i.pat[pos_q] == c)) begin
            pref_n = 1'b0;
          end
        end
        if (plen_ok) begin
          win_n = {win_q[MaxLen-2:0], 1'b1} & mask;
          if (win_n[plen_m1]) begin
            found_n = 1'b1;
          end
        end
        pos_n = pos_q + PosW'(1);
      end
    end
  end

  // Word verdict from the updated state
  always_comb begin
    unique case (cfg_i.mode)
      MODE_EXACT:  hit = pref_n && (pos_n == cfg_i.plen);
      MODE_PREFIX: hit = pref_n && (cfg_i.plen <= pos_n);
      MODE_ANY:    hit = (cfg_i.plen == '0) || (plen_le_max && found_n);
      default:     hit = 1'b0;
    endcase
    res_o.word_ok = !bad_n;
    res_o.matched = !bad_n && hit;
  end

  // Commit, or clear at the end of a word
  always_comb begin
    pos_d   = pos_q;
    pref_d  = pref_q;
    win_d   = win_q;
    found_d = found_q;
    bad_d   = bad_q;
    if (step_i) begin
      if (item_i.last) begin
        pos_d   = '0;
        pref_d  = 1'b1;
        win_d   = '0;
        found_d = 1'b0;
        bad_d   = 1'b0;
      end else begin
        pos_d   = pos_n;
        pref_d  = pref_n;
        win_d   = win_n;
        found_d = found_n;
        bad_d   = bad_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      pref_q  <= 1'b1;
      win_q   <= '0;
      found_q <= 1'b0;
      bad_q   <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      pref_q  <= pref_d;
      win_q   <= win_d;
      found_q <= found_d;
      bad_q   <= bad_d;
    end
  end

endmodule

`default_nettype wire

[sv/wildcard_word_matcher_core.sv]
// Wildcard word matcher: streams characters of a word, reports match on the last one.
//
// Input channel: one beat per character (ch_i, has_char_i, last_i) with
// in_valid_i / in_stall_o; a beat is taken when valid is high and stall low.
// An empty word is a single beat with has_char_i low and last_i high.
// Output channel: one beat per word (matched_o, word_ok_o) with
// out_valid_o / out_stall_i, produced for the beat marked last.
// Config channel: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// ready is always high. Write only while no word is in flight.
// Path: a last beat passes the input register, then the result register.
// Throughput: one character per cycle unless a last beat waits on a held result,
// set by the input register, the combinational shift-and update and the output register.
// Stall: a held result keeps the output register; character beats still
// flow, and a new last beat waits in the input register until it frees.
// Reset clears all configuration registers and the per-word state.
`default_nettype none

module wildcard_word_matcher_core
  import wwm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [7:0]          ch_i,
  input  wire logic                has_char_i,
  input  wire logic                last_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     matched_o,
  output logic                     word_ok_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t  cfg;
  item_t in_item;
  item_t s1_item;
  logic  s1_valid;
  logic  step;
  logic  out_free;
  res_t  res;
  res_t  res_q;
  logic  out_valid_q;
  logic  out_valid_d;

  assign in_item.ch       = ch_i;
  assign in_item.has_char = has_char_i;
  assign in_item.last     = last_i;

  wwm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  wwm_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .take_i     (step),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  // A last beat needs a free output slot; other beats always proceed
  assign out_free = !out_valid_q || !out_stall_i;
  assign step     = s1_valid && (!s1_item.last || out_free);

  wwm_match u_match (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (step),
    .item_i (s1_item),
    .res_o  (res)
  );

  // Result register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (step && s1_item.last) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && s1_item.last) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = res_q.matched;
  assign word_ok_o   = res_q.word_ok;

`ifndef SYNTH
  // A match is never reported for an invalid word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!matched_o || word_ok_o))
    else $error("matched set on invalid word");

  // The input side stalls only while a beat is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid)
    else $error("stall with empty input register");

  // A consumed last beat always yields a result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && s1_item.last) |=> out_valid_o)
    else $error("last beat produced no result");
`endif

endmodule

`default_nettype wire

[dv/tb_wildcard_word_matcher_core.sv]
// Testbench for the wildcard word matcher core: streamed words checked against a local predictor.
`timescale 1ns / 100ps

module tb_wildcard_word_matcher_core;
  import wwm_pkg::*;

  localparam logic [1:0] ModeUnused  = 2'd3;
  localparam int         TargetBeats = 1000;
  localparam int         LongHold    = 300;
  localparam int         DrainCycles = 4;
  localparam longint     LimitNs     = 3_000_000;

  typedef logic [8*MaxLen-1:0] pat_bits_t;
  typedef logic [7:0] word_q_t[$];

  // Predicts the verdict of every word and holds the ones not yet seen.
  class verdict_board;
    logic [1:0]      mode;
    logic [PosW-1:0] plen;
    pat_bits_t       pat;
    logic [PosW-1:0] pos;
    bit              prefix_ok;
    logic [MaxLen-1:0] window;
    bit              found;
    bit              bad;
    res_t            verdicts_due[$];
    int              errors;

    function new();
      mode = '0;
      plen = '0;
      pat = '0;
      errors = 0;
      clear_word();
    endfunction

    function void clear_word();
      pos = '0;
      prefix_ok = 1'b1;
      window = '0;
      found = 1'b0;
      bad = 1'b0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CfgDataW-1:0] d);
      int w;
      w = int'(idx) - int'(REG_PAT0);
      case (idx)
        REG_MODE: mode = d[1:0];
        REG_PLEN: plen = d[PosW-1:0];
        REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3, REG_PAT4: pat[64*w +: 64] = d;
        default: ;
      endcase
    endfunction

    // '?' in the pattern takes any character; everything else must be equal.
    function bit pos_hit(int i, logic [7:0] c);
      logic [7:0] p;
      p = pat[8*i +: 8];
      return (p == WildChar) || (p == c);
    endfunction

    function void take_char(logic [7:0] raw);
      logic [7:0] c;
      logic [MaxLen-1:0] mask;
      c = raw;
      if (raw >= UpperA && raw <= UpperZ) c = raw + CaseStep;
      if (!((c >= UpperA && c <= UpperZ) || (c >= LowerA && c <= LowerZ))) bad = 1'b1;
      // beyond the longest valid word: flag it, count no further
      if (pos >= MaxLen) begin
        bad = 1'b1;
        return;
      end
      if (plen <= MaxLen && pos < plen && !pos_hit(pos, c)) prefix_ok = 1'b0;
      // shift-and step over all pattern positions
      if (plen >= 1 && plen <= MaxLen) begin
        mask = '0;
        for (int j = 0; j < plen; j++) begin
          if (pos_hit(j, c)) mask[j] = 1'b1;
        end
        window = {window[MaxLen-2:0], 1'b1} & mask;
        if (window[plen-1]) found = 1'b1;
      end
      pos = pos + 1'b1;
    endfunction

    function void note_beat(logic [7:0] c, logic has, logic fin);
      res_t v;
      logic hit;
      if (has) take_char(c);
      if (!fin) return;
      case (mode)
        MODE_EXACT:  hit = prefix_ok && (pos == plen);
        MODE_PREFIX: hit = prefix_ok && (plen <= pos);
        MODE_ANY:    hit = (plen == 0) || (plen <= MaxLen && found);
        default:     hit = 1'b0;
      endcase
      v.matched = !bad && hit;
      v.word_ok = !bad;
      verdicts_due.push_back(v);
      clear_word();
    endfunction

    function void check_verdict(logic m, logic ok);
      res_t want;
      if (verdicts_due.size() == 0) begin
        $error("result with none due: matched=%0b word_ok=%0b", m, ok);
        errors++;
        return;
      end
      want = verdicts_due.pop_front();
      if (m !== want.matched) begin
        $error("matched: expected %0b, got %0b", want.matched, m);
        errors++;
      end
      if (ok !== want.word_ok) begin
        $error("word_ok: expected %0b, got %0b", want.word_ok, ok);
        errors++;
      end
    endfunction

    function int outstanding();
      return verdicts_due.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [7:0]          ch_i;
  logic                has_char_i;
  logic                last_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                matched_o;
  logic                word_ok_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  verdict_board sb = new();

  bit              quiet;
  int              hold_asked;
  int              beats_sent;
  logic [1:0]      cur_mode;
  logic [PosW-1:0] cur_plen;
  pat_bits_t       cur_pat;
  int              alpha;

  wildcard_word_matcher_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .ch_i        (ch_i),
    .has_char_i  (has_char_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .matched_o   (matched_o),
    .word_ok_o   (word_ok_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #(LimitNs);
    $display("simulation failed");
    $finish;
  end

  // Result side: check each accepted beat, stall in random bursts or one long hold
  initial begin : result_side
    int stall_left;
    int hold_done;
    stall_left = 0;
    hold_done = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) sb.check_verdict(matched_o, word_ok_o);
      if (stall_left == 0) begin
        if (hold_done != hold_asked) begin
          hold_done = hold_asked;
          stall_left = LongHold;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 5);
        end
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // One input beat, optionally after a short idle burst
  task automatic send_beat(logic [7:0] c, logic has, logic fin);
    int gap;
    gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 5) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i <= c;
    has_char_i <= has;
    last_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_beat(c, has, fin);
    if (has || fin) beats_sent++;
  endtask

  // A word; empty beats sprinkled in, optionally closed by an empty last beat
  task automatic send_word(word_q_t w, bit tail_empty);
    if (w.size() == 0) begin
      send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      return;
    end
    foreach (w[i]) begin
      if ($urandom_range(0, 15) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_beat(w[i], 1'b1, (i == w.size() - 1) && !tail_empty);
    end
    if (tail_empty) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic send_text(string s, bit tail_empty = 1'b0);
    word_q_t w;
    for (int i = 0; i < s.len(); i++) w.push_back(s[i]);
    send_word(w, tail_empty);
  endtask

  // Stop offering and wait until every verdict is back and the core is quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write all registers; valid stays high across the writes
  task automatic configure(logic [63:0] mode_d, logic [63:0] plen_d, pat_bits_t pat);
    logic [63:0] vals [7];
    vals[0] = mode_d;
    vals[1] = plen_d;
    for (int w = 0; w < NumPatW; w++) vals[2 + w] = pat[64*w +: 64];
    for (int i = 0; i < 7; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= cfg_reg_e'(i);
      cfg_data_i <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.set_reg(cfg_reg_e'(i), vals[i]);
    end
    cfg_valid_i <= 1'b0;
    cur_mode = mode_d[1:0];
    cur_plen = plen_d[PosW-1:0];
    cur_pat = pat;
  endtask

  function automatic pat_bits_t pat_of(string s);
    pat_bits_t p;
    p = '0;
    for (int i = 0; i < s.len() && i < MaxLen; i++) p[8*i +: 8] = s[i];
    return p;
  endfunction

  function automatic word_q_t letters(int n, logic [7:0] c);
    word_q_t w;
    repeat (n) w.push_back(c);
    return w;
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = $urandom_range(0, 1) ? UpperA : LowerA;
    return base + 8'($urandom_range(0, alpha - 1));
  endfunction

  // Half the words built around the pattern, plus plain, overlong, near-full, noisy and empty words
  function automatic word_q_t build_word();
    word_q_t w;
    int kind;
    int span;
    logic [7:0] p;
    kind = $urandom_range(0, 19);
    span = (cur_plen > MaxLen) ? MaxLen : cur_plen;
    if (kind <= 8 || kind == 19) begin
      if (!(cur_mode == MODE_EXACT && $urandom_range(0, 1))) begin
        repeat ($urandom_range(0, 3)) w.push_back(rand_letter());
      end
      for (int i = 0; i < span; i++) begin
        p = cur_pat[8*i +: 8];
        if (p == WildChar) w.push_back(rand_letter());
        else if (p >= LowerA && p <= LowerZ && $urandom_range(0, 1)) w.push_back(p - CaseStep);
        else w.push_back(p);
      end
      if (!(cur_mode == MODE_EXACT && $urandom_range(0, 1))) begin
        repeat ($urandom_range(0, 3)) w.push_back(rand_letter());
      end
      // broken word: one character overwritten by any byte
      if (kind == 19 && w.size() != 0) begin
        w[$urandom_range(0, w.size() - 1)] = 8'($urandom_range(0, 255));
      end
    end else if (kind <= 13) begin
      repeat ($urandom_range(0, 10)) w.push_back(rand_letter());
    end else if (kind == 14) begin
      repeat ($urandom_range(41, 44)) w.push_back(rand_letter());
    end else if (kind == 15) begin
      repeat ($urandom_range(39, 40)) w.push_back(rand_letter());
    end else if (kind <= 17) begin
      repeat ($urandom_range(1, 8)) w.push_back(8'($urandom_range(0, 255)));
    end
    return w;
  endfunction

  // Stimulus
  initial begin : stimulus
    word_q_t w;
    pat_bits_t pat;
    logic [63:0] mode_d;
    logic [63:0] plen_d;
    int phase;
    int r;
    int plen_v;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    ch_i = '0;
    has_char_i = 1'b0;
    last_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    quiet = 1'b0;
    hold_asked = 0;
    beats_sent = 0;
    cur_mode = '0;
    cur_plen = '0;
    cur_pat = '0;
    alpha = 26;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: whole word, empty pattern
    send_text("");
    send_text("Ab");
    drain();

    configure(64'(MODE_EXACT), 64'd3, pat_of("c?t"));
    send_text("CAT");
    send_text("cot");
    send_text("cats");
    send_text("c@t");
    send_text("c?t");
    drain();

    configure(64'(MODE_PREFIX), 64'd3, pat_of("c?t"));
    send_text("Catalog");
    send_text("ca");
    send_text("dog", 1'b1);
    drain();

    // window at the very end of a full-length word, then one letter too many
    configure(64'(MODE_ANY), 64'd3, pat_of("a?a"));
    send_text("bAnana");
    send_text("xyz");
    w = letters(37, "z");
    w.push_back("a");
    w.push_back("b");
    w.push_back("a");
    send_word(w, 1'b0);
    w.push_front("z");
    send_word(w, 1'b0);
    drain();

    // empty pattern
    configure(64'(MODE_ANY), 64'd0, pat_of("zz"));
    send_text("q");
    send_text("Qz", 1'b1);
    drain();
    configure({62'h3fff_ffff_ffff_ffff, MODE_PREFIX}, 64'd0, pat_of("x"));
    send_text("hello");
    drain();

    // pattern longer than the longest word, upper register bits set
    configure(64'(MODE_PREFIX), {58'h3ff_ffff_ffff_ffff, 6'd41}, pat_of("abc"));
    send_text("abc");
    drain();

    // all-wildcard pattern of maximal length
    configure(64'(MODE_EXACT), 64'd40, {MaxLen{WildChar}});
    send_word(letters(40, "k"), 1'b0);
    send_word(letters(39, "K"), 1'b0);
    drain();

    // unused mode, then the byte extremes and the neighbors of the letter ranges
    configure(64'(ModeUnused), 64'd2, pat_of("ab"));
    send_text("ab");
    w = '{8'h00, 8'hFF, 8'h40, 8'h5B, 8'h60, 8'h7B};
    send_word(w, 1'b0);
    drain();

    // random phases
    phase = 0;
    while (beats_sent < TargetBeats) begin
      quiet = (beats_sent >= TargetBeats - 150);
      alpha = $urandom_range(0, 1) ? 3 : 26;
      r = $urandom_range(0, 9);
      if (r == 0) plen_v = 0;
      else if (r == 1) plen_v = MaxLen;
      else if (r == 2) plen_v = $urandom_range(41, 63);
      else plen_v = $urandom_range(1, 6);
      pat = {10{$urandom}};
      for (int i = 0; i < plen_v && i < MaxLen; i++) begin
        r = $urandom_range(0, 9);
        if (r <= 2) pat[8*i +: 8] = WildChar;
        else if (r <= 8) pat[8*i +: 8] = LowerA + 8'($urandom_range(0, alpha - 1));
      end
      mode_d = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'd0;
      mode_d[1:0] = 2'($urandom_range(0, 3));
      plen_d = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'd0;
      plen_d[PosW-1:0] = PosW'(plen_v);
      configure(mode_d, plen_d, pat);
      // one long hold on the result side while words keep coming
      if (phase == 1) hold_asked++;
      repeat ($urandom_range(8, 25)) send_word(build_word(), $urandom_range(0, 7) == 0);
      drain();
      phase++;
    end

    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
